// ===== hw/rtl/lavm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lavm_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int POSITION_BITS  = 32;
  localparam int UNIT_FRAC_BITS = 14;
  localparam int UNIT_W         = UNIT_FRAC_BITS + 2;
  localparam int CORDIC_STEPS   = 30;
  localparam int STEP_W         = $clog2(CORDIC_STEPS);
  localparam int XY_W           = 33;
  localparam int Z_W            = 32;
  localparam int PROD_W         = UNIT_W + POSITION_BITS;
  localparam int SUM_W          = PROD_W + 3;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1 << UNIT_FRAC_BITS);

  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic [ANGLE_BITS-1:0]           pitch_angle;
    logic [ANGLE_BITS-1:0]           yaw_angle;
    logic signed [POSITION_BITS-1:0] pos_x;
    logic signed [POSITION_BITS-1:0] pos_y;
    logic signed [POSITION_BITS-1:0] pos_z;
  } pose_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0]        right_x;
    logic signed [UNIT_W-1:0]        right_z;
    logic signed [UNIT_W-1:0]        upward_x;
    logic signed [UNIT_W-1:0]        upward_y;
    logic signed [UNIT_W-1:0]        upward_z;
    logic signed [UNIT_W-1:0]        forward_x;
    logic signed [UNIT_W-1:0]        forward_y;
    logic signed [UNIT_W-1:0]        forward_z;
    logic signed [POSITION_BITS-1:0] offset_right;
    logic signed [POSITION_BITS-1:0] offset_upward;
    logic signed [POSITION_BITS-1:0] offset_forward;
    logic                            degenerate;
  } view_t;

  typedef struct packed {
    logic                            valid;
    logic signed [XY_W-1:0]          x_p;
    logic signed [XY_W-1:0]          y_p;
    logic signed [Z_W-1:0]           z_p;
    logic signed [XY_W-1:0]          x_y;
    logic signed [XY_W-1:0]          y_y;
    logic signed [Z_W-1:0]           z_y;
    logic [1:0]                      quad_p;
    logic [1:0]                      quad_y;
    logic signed [POSITION_BITS-1:0] pos_x;
    logic signed [POSITION_BITS-1:0] pos_y;
    logic signed [POSITION_BITS-1:0] pos_z;
  } cordic_t;

  function automatic logic signed [UNIT_W-1:0] clamp_unit(input logic signed [XY_W:0] t);
    if (t > (XY_W+1)'(UNIT_ONE)) return UNIT_ONE;
    if (t < -(XY_W+1)'(UNIT_ONE)) return -UNIT_ONE;
    return UNIT_W'(t);
  endfunction

  function automatic logic signed [UNIT_W-1:0] round_q30(input logic signed [XY_W-1:0] v);
    logic signed [XY_W:0] t;
    t = ((XY_W+1)'(v) + (XY_W+1)'(1 << (29 - UNIT_FRAC_BITS))) >>> (30 - UNIT_FRAC_BITS);
    return clamp_unit(t);
  endfunction

  function automatic logic signed [UNIT_W-1:0] round_prod(input logic signed [XY_W:0] p);
    logic signed [XY_W:0] t;
    t = (p + (XY_W+1)'(1 << (UNIT_FRAC_BITS - 1))) >>> UNIT_FRAC_BITS;
    return clamp_unit(t);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lavm_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lavm_cordic_cell (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         en,
  input  wire [lavm_pkg::STEP_W-1:0]  step,
  input  lavm_pkg::cordic_t           src,
  output lavm_pkg::cordic_t           dst
);
  import lavm_pkg::*;

  cordic_t                nxt;
  logic signed [Z_W-1:0]  atan;

  always_comb begin
    atan = Z_W'(ATAN_TURN[step]);
    nxt = src;
    if (src.z_p >= 0) begin
      nxt.x_p = src.x_p - (src.y_p >>> step);
      nxt.y_p = src.y_p + (src.x_p >>> step);
      nxt.z_p = src.z_p - atan;
    end else begin
      nxt.x_p = src.x_p + (src.y_p >>> step);
      nxt.y_p = src.y_p - (src.x_p >>> step);
      nxt.z_p = src.z_p + atan;
    end
    if (src.z_y >= 0) begin
      nxt.x_y = src.x_y - (src.y_y >>> step);
      nxt.y_y = src.y_y + (src.x_y >>> step);
      nxt.z_y = src.z_y - atan;
    end else begin
      nxt.x_y = src.x_y + (src.y_y >>> step);
      nxt.y_y = src.y_y - (src.x_y >>> step);
      nxt.z_y = src.z_y + atan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst.valid <= 1'b0;
    end else if (en) begin
      dst <= nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lavm_post.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lavm_post (
  input  wire                clk,
  input  wire                rst,
  input  wire                en,
  input  lavm_pkg::cordic_t  src,
  output logic               view_valid,
  output lavm_pkg::view_t    view
);
  import lavm_pkg::*;

  logic signed [XY_W-1:0] cx_p, cy_p, cx_y, cy_y;
  logic signed [POSITION_BITS-1:0] pa [3];
  logic signed [POSITION_BITS-1:0] pb [3];
  logic signed [POSITION_BITS-1:0] pc [3];

  logic va;
  logic signed [UNIT_W-1:0] cp, sp, cyw, syw;
  logic vb, degen_b;
  logic signed [UNIT_W-1:0] fb0, fb1, fb2, rb0, rb2;
  logic vc, degen_c;
  logic signed [UNIT_W-1:0] fc0, fc1, fc2, rc0, rc2, uc0, uc1, uc2;
  logic vd, degen_d;
  logic signed [UNIT_W-1:0] fd0, fd1, fd2, rd0, rd2, ud0, ud1, ud2;
  logic signed [PROD_W-1:0] pr [9];
  logic signed [SUM_W-1:0] s_r, s_u, s_f;

  function automatic logic signed [POSITION_BITS-1:0] offset(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] q;
    q = (SUM_W'(1 << (UNIT_FRAC_BITS - 1)) - s) >>> UNIT_FRAC_BITS;
    if (q > $signed(SUM_W'({1'b0, {(POSITION_BITS-1){1'b1}}})))
      return {1'b0, {(POSITION_BITS-1){1'b1}}};
    if (q < -$signed(SUM_W'({1'b0, {(POSITION_BITS-1){1'b1}}})) - SUM_W'(1))
      return {1'b1, {(POSITION_BITS-1){1'b0}}};
    return POSITION_BITS'(q);
  endfunction

  always_comb begin
    case (src.quad_p)
      2'd0:    begin cx_p = src.x_p;  cy_p = src.y_p;  end
      2'd1:    begin cx_p = -src.y_p; cy_p = src.x_p;  end
      2'd2:    begin cx_p = -src.x_p; cy_p = -src.y_p; end
      default: begin cx_p = src.y_p;  cy_p = -src.x_p; end
    endcase
    case (src.quad_y)
      2'd0:    begin cx_y = src.x_y;  cy_y = src.y_y;  end
      2'd1:    begin cx_y = -src.y_y; cy_y = src.x_y;  end
      2'd2:    begin cx_y = -src.x_y; cy_y = -src.y_y; end
      default: begin cx_y = src.y_y;  cy_y = -src.x_y; end
    endcase
    s_r = SUM_W'(pr[0]) + SUM_W'(pr[1]) + SUM_W'(pr[2]);
    s_u = SUM_W'(pr[3]) + SUM_W'(pr[4]) + SUM_W'(pr[5]);
    s_f = SUM_W'(pr[6]) + SUM_W'(pr[7]) + SUM_W'(pr[8]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      view_valid <= 1'b0;
    end else if (en) begin
      va <= src.valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      view_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp  <= round_q30(cx_p);
      sp  <= round_q30(cy_p);
      cyw <= round_q30(cx_y);
      syw <= round_q30(cy_y);
      pa[0] <= src.pos_x;
      pa[1] <= src.pos_y;
      pa[2] <= src.pos_z;

      fb0 <= round_prod(-(XY_W+1)'(cp * syw));
      fb1 <= sp;
      fb2 <= round_prod(-(XY_W+1)'(cp * cyw));
      degen_b <= (cp == '0);
      if (cp == '0) begin
        rb0 <= '0;
        rb2 <= '0;
      end else if (cp > 0) begin
        rb0 <= cyw;
        rb2 <= -syw;
      end else begin
        rb0 <= -cyw;
        rb2 <= syw;
      end
      pb <= pa;

      fc0 <= fb0; fc1 <= fb1; fc2 <= fb2;
      rc0 <= rb0; rc2 <= rb2;
      uc0 <= round_prod((XY_W+1)'(fb1 * rb2));
      uc1 <= round_prod((XY_W+1)'(fb2 * rb0) - (XY_W+1)'(fb0 * rb2));
      uc2 <= round_prod(-(XY_W+1)'(fb1 * rb0));
      degen_c <= degen_b;
      pc <= pb;

      fd0 <= fc0; fd1 <= fc1; fd2 <= fc2;
      rd0 <= rc0; rd2 <= rc2;
      ud0 <= uc0; ud1 <= uc1; ud2 <= uc2;
      degen_d <= degen_c;
      pr[0] <= PROD_W'(rc0 * pc[0]);
      pr[1] <= '0;
      pr[2] <= PROD_W'(rc2 * pc[2]);
      pr[3] <= PROD_W'(uc0 * pc[0]);
      pr[4] <= PROD_W'(uc1 * pc[1]);
      pr[5] <= PROD_W'(uc2 * pc[2]);
      pr[6] <= PROD_W'(fc0 * pc[0]);
      pr[7] <= PROD_W'(fc1 * pc[1]);
      pr[8] <= PROD_W'(fc2 * pc[2]);

      view.right_x        <= rd0;
      view.right_z        <= rd2;
      view.upward_x       <= ud0;
      view.upward_y       <= ud1;
      view.upward_z       <= ud2;
      view.forward_x      <= fd0;
      view.forward_y      <= fd1;
      view.forward_z      <= fd2;
      view.offset_right   <= offset(s_r);
      view.offset_upward  <= offset(s_u);
      view.offset_forward <= offset(s_f);
      view.degenerate     <= degen_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/look_at_view_matrix_unit.sv =====
// Pipeline: an accepted pose beat passes 30 rotation cells and 5 post stages on its way to its view beat.
// Throughput: one pose per cycle; the whole pipeline advances whenever the output register
// is empty or being taken, so a stalled result holds every stage.
// Reset: synchronous, active high; clears all stage valid bits, no data is cleared.
`timescale 1ns / 1ps
`default_nettype none
module look_at_view_matrix_unit (
  input  wire                clk,
  input  wire                rst,
  input  wire                pose_valid,
  output logic               pose_ready,
  input  lavm_pkg::pose_t    pose,
  output logic               view_valid,
  input  wire                view_ready,
  output lavm_pkg::view_t    view
);
  import lavm_pkg::*;

  logic                   en;
  logic [31:0]            a_p, a_y;
  cordic_t                chain [CORDIC_STEPS+1];

  assign en = !view_valid || view_ready;
  assign pose_ready = en;

  always_comb begin
    a_p = 32'(pose.pitch_angle) << (32 - ANGLE_BITS);
    a_y = 32'(pose.yaw_angle) << (32 - ANGLE_BITS);
    chain[0].valid  = pose_valid;
    chain[0].x_p    = CORDIC_GAIN;
    chain[0].y_p    = '0;
    chain[0].z_p    = Z_W'({2'b00, a_p[29:0]});
    chain[0].x_y    = CORDIC_GAIN;
    chain[0].y_y    = '0;
    chain[0].z_y    = Z_W'({2'b00, a_y[29:0]});
    chain[0].quad_p = a_p[31:30];
    chain[0].quad_y = a_y[31:30];
    chain[0].pos_x  = pose.pos_x;
    chain[0].pos_y  = pose.pos_y;
    chain[0].pos_z  = pose.pos_z;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    lavm_cordic_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .step (STEP_W'(i)),
      .src  (chain[i]),
      .dst  (chain[i+1])
    );
  end

  lavm_post u_post (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .src        (chain[CORDIC_STEPS]),
    .view_valid (view_valid),
    .view       (view)
  );

  a_degen_right: assert property (@(posedge clk) disable iff (rst)
    view_valid && view.degenerate |->
      view.right_x == '0 && view.right_z == '0 && view.offset_right == '0)
    else $error("degenerate pose with nonzero right axis");

  a_right_nonzero: assert property (@(posedge clk) disable iff (rst)
    view_valid && !view.degenerate |-> view.right_x != '0 || view.right_z != '0)
    else $error("right axis vanished on a regular pose");

  a_forward_range: assert property (@(posedge clk) disable iff (rst)
    view_valid |-> view.forward_y <= UNIT_ONE && view.forward_y >= -UNIT_ONE)
    else $error("forward axis out of unit range");

endmodule
`default_nettype wire
